// ===== rtl/core/psieve_pkg.sv =====
`timescale 1ns / 1ps
package psieve_pkg;

   localparam int LIMIT_SIZE  = 1024;
   localparam int PRIME_SLOTS = 256;

   localparam int LIMIT_W = $clog2(LIMIT_SIZE);
   localparam int WALK_W  = LIMIT_W + 1;
   localparam int SLOT_W  = $clog2(PRIME_SLOTS);
   localparam int CNT_W   = SLOT_W + 1;

   localparam logic OP_SIEVE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_MARK,
      ST_READ,
      ST_DONE
   } psieve_state_type;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic scan_read;
      logic append;
      logic mark_step;
      logic p_next;
      logic list_read;
   } psieve_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic p_over;
      logic is_comp;
      logic m_over;
   } psieve_sts_type;

endpackage

// ===== rtl/core/prime_sieve_engine_unit.sv =====
`timescale 1ns / 1ps
// Sieve of Eratosthenes engine. Raise start while busy is low to hand in one item: a sieve
// run up to req_limit (operation 0) or a read of the prime at req_index (operation 1).
// Exactly one result follows each item, shown for a single cycle with rsp_strobe high;
// the receiver cannot stall it, so it must take the result in that cycle. busy stays high
// until the cycle after the strobe. A read goes through ST_READ to ST_DONE, where the strobe
// is raised. A sieve run with limit n clears the bitmap, then checks each number from 2 up to
// n, and for each prime found marks its multiples, all through the single-port bitmap memory.
// Only the first 256 primes are kept and counted.
module prime_sieve_engine_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_operation,
   input  logic [psieve_pkg::LIMIT_W-1:0]     req_limit,
   input  logic [psieve_pkg::SLOT_W-1:0]      req_index,
   output logic                               rsp_strobe,
   output logic [psieve_pkg::CNT_W-1:0]       rsp_prime_count,
   output logic [psieve_pkg::LIMIT_W-1:0]     rsp_prime_value,
   output logic                               rsp_valid_res
);
   import psieve_pkg::*;

   psieve_cmd_type cmd;
   psieve_sts_type sts;

   psieve_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_operation),
      .sts    (sts),
      .cmd    (cmd),
      .busy   (busy),
      .done   (rsp_strobe)
   );

   psieve_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_op      (req_operation),
      .req_limit   (req_limit),
      .req_index   (req_index),
      .sts         (sts),
      .prime_count (rsp_prime_count),
      .prime_value (rsp_prime_value),
      .valid_res   (rsp_valid_res)
   );

endmodule

// ===== rtl/core/psieve_ctrl.sv =====
`timescale 1ns / 1ps
module psieve_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_op,
   input  psieve_pkg::psieve_sts_type sts,
   output psieve_pkg::psieve_cmd_type cmd,
   output logic                      busy,
   output logic                      done
);
   import psieve_pkg::*;

   psieve_state_type state_ff;
   psieve_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_op == OP_READ) ? ST_READ : ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            if (sts.clr_last) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            state_in = sts.p_over ? ST_DONE : ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            state_in = sts.is_comp ? ST_SCAN_RD : ST_MARK;
         end
         ST_MARK: begin
            if (sts.m_over) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
         end
         ST_SCAN_RD: begin
            cmd.scan_read = !sts.p_over;
         end
         ST_SCAN_CHK: begin
            cmd.append = !sts.is_comp;
            cmd.p_next = sts.is_comp;
         end
         ST_MARK: begin
            cmd.mark_step = !sts.m_over;
            cmd.p_next    = sts.m_over;
         end
         ST_READ: begin
            cmd.list_read = 1'b1;
         end
         ST_DONE: begin
            done = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== rtl/core/psieve_dp.sv =====
`timescale 1ns / 1ps
module psieve_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  psieve_pkg::psieve_cmd_type          cmd,
   input  logic                                req_op,
   input  logic [psieve_pkg::LIMIT_W-1:0]      req_limit,
   input  logic [psieve_pkg::SLOT_W-1:0]       req_index,
   output psieve_pkg::psieve_sts_type          sts,
   output logic [psieve_pkg::CNT_W-1:0]        prime_count,
   output logic [psieve_pkg::LIMIT_W-1:0]      prime_value,
   output logic                                valid_res
);
   import psieve_pkg::*;

   logic                op_ff;
   logic [LIMIT_W-1:0]  n_ff;
   logic [SLOT_W-1:0]   idx_ff;
   logic [WALK_W-1:0]   p_ff;
   logic [WALK_W-1:0]   m_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                comp_ff;
   logic [LIMIT_W-1:0]  list_q_ff;

   logic                map_mem [LIMIT_SIZE];
   logic [LIMIT_W-1:0]  list_mem [PRIME_SLOTS];

   logic                map_we;
   logic                map_wd;
   logic [LIMIT_W-1:0]  map_addr;
   logic                list_we;
   logic                read_ok;

   assign map_we   = cmd.clr_step | cmd.mark_step;
   assign map_wd   = cmd.mark_step;
   assign map_addr = cmd.scan_read ? p_ff[LIMIT_W-1:0] : m_ff[LIMIT_W-1:0];
   assign list_we  = cmd.append && (count_ff < CNT_W'(PRIME_SLOTS));

   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_addr] <= map_wd;
      end
      if (cmd.scan_read) begin
         comp_ff <= map_mem[map_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[count_ff[SLOT_W-1:0]] <= p_ff[LIMIT_W-1:0];
      end
      if (cmd.list_read) begin
         list_q_ff <= list_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load && req_op == OP_SIEVE) begin
         count_ff <= '0;
      end else if (list_we) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_op;
         n_ff   <= req_limit;
         idx_ff <= req_index;
         p_ff   <= WALK_W'(2);
         m_ff   <= '0;
      end else begin
         if (cmd.clr_step) begin
            m_ff <= m_ff + WALK_W'(1);
         end
         if (cmd.append) begin
            m_ff <= p_ff + p_ff;
         end
         if (cmd.mark_step) begin
            m_ff <= m_ff + p_ff;
         end
         if (cmd.p_next) begin
            p_ff <= p_ff + WALK_W'(1);
         end
      end
   end

   always_comb begin
      sts.clr_last = (m_ff == {1'b0, n_ff});
      sts.p_over   = (p_ff > {1'b0, n_ff});
      sts.is_comp  = comp_ff;
      sts.m_over   = (m_ff > {1'b0, n_ff});
   end

   assign read_ok     = ({1'b0, idx_ff} < count_ff);
   assign prime_count = count_ff;

   always_comb begin
      if (op_ff == OP_SIEVE) begin
         prime_value = '0;
         valid_res   = 1'b1;
      end else if (read_ok) begin
         prime_value = list_q_ff;
         valid_res   = 1'b1;
      end else begin
         prime_value = '0;
         valid_res   = 1'b0;
      end
   end

endmodule

// ===== bench/prime_sieve_checker.sv =====
`timescale 1ns / 1ps
module prime_sieve_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  logic                               req_operation,
   input  logic [psieve_pkg::LIMIT_W-1:0]     req_limit,
   input  logic [psieve_pkg::SLOT_W-1:0]      req_index,
   input  logic                               rsp_strobe,
   input  logic [psieve_pkg::CNT_W-1:0]       rsp_prime_count,
   input  logic [psieve_pkg::LIMIT_W-1:0]     rsp_prime_value,
   input  logic                               rsp_valid_res,
   output int                                 fail_count,
   output int                                 items_taken,
   output int                                 answers_seen,
   output int                                 primes_known
);
   import psieve_pkg::*;

   typedef struct {
      logic [CNT_W-1:0]   count;
      logic [LIMIT_W-1:0] value;
      logic               valid;
   } sieve_answer_type;

   sieve_answer_type         answers_due[$];
   logic [LIMIT_W-1:0]       prime_table[PRIME_SLOTS];
   bit   [LIMIT_SIZE-1:0]    crossed_out;
   int unsigned              primes_found;
   int                       shown_errors;

   initial begin
      fail_count   = 0;
      items_taken  = 0;
      answers_seen = 0;
      primes_known = 0;
      shown_errors = 0;
      primes_found = 0;
      crossed_out  = '0;
      for (int i = 0; i < PRIME_SLOTS; i++) begin
         prime_table[i] = '0;
      end
   end

   function automatic logic [CNT_W-1:0] clamped_count();
      return (primes_found > 511) ? CNT_W'(511) : CNT_W'(primes_found);
   endfunction

   function automatic void sieve_up_to(input logic [LIMIT_W-1:0] top);
      int unsigned n;
      n = top;
      if (n >= LIMIT_SIZE) begin
         n = LIMIT_SIZE - 1;
      end
      crossed_out  = '0;
      primes_found = 0;
      for (int unsigned p = 2; p <= n; p++) begin
         if (!crossed_out[p]) begin
            if (primes_found < PRIME_SLOTS) begin
               prime_table[primes_found] = p[LIMIT_W-1:0];
               primes_found++;
            end
            for (int unsigned m = p + p; m <= n; m += p) begin
               crossed_out[m] = 1'b1;
            end
         end
      end
   endfunction

   function automatic sieve_answer_type answer_for(input logic op,
                                                   input logic [LIMIT_W-1:0] lim,
                                                   input logic [SLOT_W-1:0] idx);
      sieve_answer_type a;
      if (op == OP_SIEVE) begin
         sieve_up_to(lim);
         a.count = clamped_count();
         a.value = '0;
         a.valid = 1'b1;
      end else begin
         a.count = clamped_count();
         if (idx < primes_found && idx < PRIME_SLOTS) begin
            a.value = prime_table[idx];
            a.valid = 1'b1;
         end else begin
            a.value = '0;
            a.valid = 1'b0;
         end
      end
      return a;
   endfunction

   always @(posedge clock) begin
      sieve_answer_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            answers_seen <= answers_seen + 1;
            if (answers_due.size() == 0) begin
               fail_count <= fail_count + 1;
               if (shown_errors < 10) begin
                  $display("%0t: unexpected result count=%0d value=%0d valid=%0b", $realtime,
                           rsp_prime_count, rsp_prime_value, rsp_valid_res);
               end
               shown_errors++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_prime_count !== want.count || rsp_prime_value !== want.value ||
                   rsp_valid_res !== want.valid) begin
                  fail_count <= fail_count + 1;
                  if (shown_errors < 10) begin
                     $display("%0t: mismatch count exp %0d got %0d", $realtime,
                              want.count, rsp_prime_count);
                     $display("   value exp %0d got %0d, valid exp %0b got %0b",
                              want.value, rsp_prime_value, want.valid, rsp_valid_res);
                  end
                  shown_errors++;
               end
            end
         end
         if (start && !busy) begin
            answers_due.push_back(answer_for(req_operation, req_limit, req_index));
            items_taken  <= items_taken + 1;
            primes_known <= primes_found;
         end
      end
   end

endmodule

// ===== bench/prime_sieve_engine_unit_tb.sv =====
`timescale 1ns / 1ps
module prime_sieve_engine_unit_tb;
   import psieve_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_ITEMS = 40;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_operation;
   logic [LIMIT_W-1:0] req_limit;
   logic [SLOT_W-1:0]  req_index;
   logic               rsp_strobe;
   logic [CNT_W-1:0]   rsp_prime_count;
   logic [LIMIT_W-1:0] rsp_prime_value;
   logic               rsp_valid_res;

   int fail_count;
   int items_taken;
   int answers_seen;
   int primes_known;
   int quiet_cycles;
   int sieve_runs;
   int prime_reads;

   prime_sieve_engine_unit dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_limit       (req_limit),
      .req_index       (req_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_prime_count (rsp_prime_count),
      .rsp_prime_value (rsp_prime_value),
      .rsp_valid_res   (rsp_valid_res)
   );

   prime_sieve_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_limit       (req_limit),
      .req_index       (req_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_prime_count (rsp_prime_count),
      .rsp_prime_value (rsp_prime_value),
      .rsp_valid_res   (rsp_valid_res),
      .fail_count      (fail_count),
      .items_taken     (items_taken),
      .answers_seen    (answers_seen),
      .primes_known    (primes_known)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout with %0d results outstanding", items_taken - answers_seen);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // leaves start high so back-to-back items need no extra edge
   task automatic issue(input logic op, input logic [LIMIT_W-1:0] lim,
                        input logic [SLOT_W-1:0] idx);
      req_operation <= op;
      req_limit     <= lim;
      req_index     <= idx;
      start         <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (op == OP_SIEVE) sieve_runs++;
      else prime_reads++;
   endtask

   task automatic sieve(input logic [LIMIT_W-1:0] lim);
      issue(OP_SIEVE, lim, SLOT_W'($urandom));
   endtask

   task automatic read_prime(input logic [SLOT_W-1:0] idx);
      issue(OP_READ, LIMIT_W'($urandom), idx);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (items_taken != answers_seen) @(posedge clock);
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(99);
      if (pick < 40) begin
         pick = $urandom_range(99);
         if (pick < 60) sieve(LIMIT_W'($urandom_range(0, 64)));
         else if (pick < 90) sieve(LIMIT_W'($urandom_range(65, 300)));
         else sieve(LIMIT_W'($urandom_range(301, 1023)));
      end else if (primes_known > 0 && $urandom_range(99) < 70) begin
         read_prime(SLOT_W'($urandom_range(0, primes_known - 1)));
      end else begin
         read_prime(SLOT_W'($urandom));
      end
   endtask

   initial begin
      int idle_pct[3];
      idle_pct     = '{0, 47, 22};
      quiet_cycles = 0;
      sieve_runs   = 0;
      prime_reads  = 0;
      reset         = 1'b1;
      start         = 1'b0;
      req_operation = OP_SIEVE;
      req_limit     = '0;
      req_index     = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reads before any sieve run, then sieve runs at small and edge limits, each followed by reads
      read_prime(SLOT_W'(0));
      read_prime(SLOT_W'(255));
      sieve(LIMIT_W'(0));
      read_prime(SLOT_W'(0));
      sieve(LIMIT_W'(1));
      read_prime(SLOT_W'(0));
      sieve(LIMIT_W'(2));
      read_prime(SLOT_W'(0));
      read_prime(SLOT_W'(1));
      sieve(LIMIT_W'(1023));
      read_prime(SLOT_W'(0));
      read_prime(SLOT_W'(171));
      read_prime(SLOT_W'(172));
      read_prime(SLOT_W'(255));
      read_prime(SLOT_W'(128));
      sieve(LIMIT_W'(10));
      read_prime(SLOT_W'(3));
      read_prime(SLOT_W'(4));
      read_prime(SLOT_W'(171));
      sieve(LIMIT_W'(512));
      read_prime(SLOT_W'(96));
      read_prime(SLOT_W'(97));
      sieve(LIMIT_W'(3));
      read_prime(SLOT_W'(1));
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            while ($urandom_range(99) < idle_pct[ph]) begin
               start <= 1'b0;
               @(posedge clock);
            end
            random_item();
         end
         drain();
      end

      repeat (20) @(posedge clock);
      $display("ran %0d sieve runs and %0d prime reads, %0d results compared",
               sieve_runs, prime_reads, answers_seen);
      $display("idle phases at 0, 47 and 22 percent of cycles on the request side");
      if (fail_count == 0 && items_taken == answers_seen) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
